/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the histogram range block, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define HARNG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define HARNG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* design/harng_pkg.sv */
// ----------------------------------------------------------------------------
// harng_pkg
// shared types and constants of the histogram auto range unit
// ----------------------------------------------------------------------------
package harng_pkg;

  localparam int unsigned COUNT_W = 21;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned KEEP_W = 17;
  localparam int unsigned RANGE_W = 33;
  localparam int unsigned QDEPTH = 4;

  localparam logic [KEEP_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [COUNT_W-1:0] MINC_RESET = 21'd16;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 17'd62259;
  localparam logic [RANGE_W-1:0] LOW_RESET = 33'h0_FFFF_0000;

  localparam logic [1:0] ACT_COUNT = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_MAP = 2'd2;

  localparam logic [1:0] REG_MIN_COUNT = 2'd0;
  localparam logic [1:0] REG_KEEP = 2'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [15:0] pixel_in;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;
  } out_t;

  typedef enum logic [1:0] {
    K_COUNT,
    K_CLOSE,
    K_MAP,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic [15:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } ctl_t;

endpackage

/* design/harng_ram.sv */
// ----------------------------------------------------------------------------
// harng_ram
// simple dual port ram, one write and one registered read
// ----------------------------------------------------------------------------
module harng_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 32769
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/harng_front.sv */
// ----------------------------------------------------------------------------
// harng_front
// accepts requests, decodes the action and queues commands for the back end
// ----------------------------------------------------------------------------
module harng_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  harng_pkg::in_t    in_data_i,
  output logic              cmd_valid_o,
  output harng_pkg::cmd_t   cmd_o,
  input  harng_pkg::ctl_t   ctl_i
);

  localparam int unsigned PW = $clog2(harng_pkg::QDEPTH);

  harng_pkg::cmd_t q_mem_q [harng_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   cnt_q;
  logic push, pop;
  harng_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.pixel = in_data_i.pixel_in;
    case (in_data_i.action)
      harng_pkg::ACT_COUNT: cmd_in.kind = harng_pkg::K_COUNT;
      harng_pkg::ACT_CLOSE: cmd_in.kind = harng_pkg::K_CLOSE;
      harng_pkg::ACT_MAP:   cmd_in.kind = harng_pkg::K_MAP;
      default:              cmd_in.kind = harng_pkg::K_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == (PW+1)'(harng_pkg::QDEPTH)) || ctl_i.busy;
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = ctl_i.pop && (cnt_q != '0);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/harng_back.sv */
// ----------------------------------------------------------------------------
// harng_back
// executes commands: histogram update, frame close with range blend, mapping
// ----------------------------------------------------------------------------
module harng_back #(
  parameter int unsigned BUCKETS = 32769
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  harng_pkg::cmd_t  cmd_i,
  output harng_pkg::ctl_t  ctl_o,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [20:0]      cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output harng_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(BUCKETS);
  localparam int unsigned VW = AW + 1;
  localparam int unsigned LW = (VW > 16) ? VW : 16;
  localparam int unsigned MB = (LW > 17) ? LW : 17;
  localparam int unsigned PW = harng_pkg::KEEP_W + MB;
  localparam int unsigned ACW = PW + 1;
  localparam int unsigned RW = harng_pkg::RANGE_W;
  localparam int unsigned CW = harng_pkg::COUNT_W;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CNT, ST_SCAN, ST_TAIL, ST_BLEND, ST_MPREP, ST_MNUM, ST_MDIV
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]   minc_q, minc_d;
  logic [harng_pkg::KEEP_W-1:0] keep_q, keep_d;
  logic [AW-1:0]   addr_q, addr_d, cnt_addr_q, cnt_addr_d, scan_idx_q, scan_idx_d;
  logic            scan_vld_q, scan_vld_d;
  logic [LW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [15:0]     pix_q, pix_d;
  logic [2:0]      step_q, step_d;
  logic [PW-1:0]   prod_q, prod_d;
  logic [ACW-1:0]  acc_q, acc_d;
  logic [RW-1:0]   new_low_q, new_low_d;
  logic [RW-1:0]   slow_q, slow_d, shigh_q, shigh_d;
  logic            first_q, first_d;
  logic [RW-1:0]   diff_q, diff_d, den_q, den_d;
  logic [40:0]     rem_q, rem_d, dsh_q, dsh_d;
  logic [3:0]      k_q, k_d;
  logic [7:0]      qt_q, qt_d;
  harng_pkg::out_t out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr, idx;
  logic [CW-1:0]   wdata, rdata;
  logic            out_free, last_addr;
  logic [16:0]     idx17;
  logic [harng_pkg::KEEP_W-1:0] w, wc, mul_a;
  logic [MB-1:0]   mul_b;
  logic [LW-1:0]   v;
  logic [RW-1:0]   pq;
  logic            ge;

  harng_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_addr = (addr_q == AW'(BUCKETS - 1));
  assign idx17     = ({1'b0, cmd_i.pixel} + 17'd1) >> 1;
  assign idx       = (32'(idx17) >= 32'(BUCKETS)) ? AW'(BUCKETS - 1) : AW'(idx17);
  assign raddr     = (state_q == ST_SCAN) ? addr_q : idx;
  assign w         = (keep_q > harng_pkg::ONE_Q16) ? harng_pkg::ONE_Q16 : keep_q;
  assign wc        = harng_pkg::ONE_Q16 - w;
  assign v         = LW'({scan_idx_q, 1'b0});
  assign pq        = {1'b0, pix_q, 16'b0};
  assign ge        = (rem_q >= dsh_q);

  // operand select for the shared blend multiplier
  always_comb begin
    case (step_q)
      3'd0:    begin mul_a = w;  mul_b = MB'(slow_q[15:0]);   end
      3'd1:    begin mul_a = w;  mul_b = MB'(slow_q[32:16]);  end
      3'd2:    begin mul_a = wc; mul_b = MB'(lo_q);           end
      3'd3:    begin mul_a = w;  mul_b = MB'(shigh_q[15:0]);  end
      3'd4:    begin mul_a = w;  mul_b = MB'(shigh_q[32:16]); end
      default: begin mul_a = wc; mul_b = MB'(hi_q);           end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    minc_d      = minc_q;
    keep_d      = keep_q;
    addr_d      = addr_q;
    cnt_addr_d  = cnt_addr_q;
    scan_idx_d  = scan_idx_q;
    scan_vld_d  = scan_vld_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pix_d       = pix_q;
    step_d      = step_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    new_low_d   = new_low_q;
    slow_d      = slow_q;
    shigh_d     = shigh_q;
    first_d     = first_q;
    diff_d      = diff_q;
    den_d       = den_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    k_d         = k_q;
    qt_d        = qt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o.pop   = 1'b0;
    ctl_o.busy  = (state_q == ST_INIT);
    we          = 1'b0;
    waddr       = addr_q;
    wdata       = '0;

    if (cfg_valid_i) begin
      if (cfg_index_i == harng_pkg::REG_MIN_COUNT) minc_d = cfg_data_i;
      if (cfg_index_i == harng_pkg::REG_KEEP) keep_d = cfg_data_i[harng_pkg::KEEP_W-1:0];
    end

    // scan data arrives in the cycle after its address
    if ((state_q == ST_SCAN || state_q == ST_TAIL) && scan_vld_q && rdata > minc_q) begin
      if (v < lo_q) lo_d = v;
      if (v > hi_q) hi_d = v;
    end

    case (state_q)
      ST_INIT: begin
        we     = 1'b1;
        addr_d = addr_q + 1'b1;
        if (last_addr) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          ctl_o.pop = 1'b1;
          pix_d     = cmd_i.pixel;
          out_d     = '{pixel_out: 8'd0, range_low: slow_q, range_high: shigh_q};
          case (cmd_i.kind)
            harng_pkg::K_COUNT: begin
              cnt_addr_d = idx;
              state_d    = ST_CNT;
            end
            harng_pkg::K_CLOSE: begin
              addr_d     = '0;
              scan_vld_d = 1'b0;
              lo_d       = LW'(16'hFFFF);
              hi_d       = '0;
              state_d    = ST_SCAN;
            end
            harng_pkg::K_MAP: state_d = ST_MPREP;
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      ST_CNT: begin
        we          = 1'b1;
        waddr       = cnt_addr_q;
        wdata       = (rdata == harng_pkg::COUNT_MAX) ? rdata : rdata + 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_SCAN: begin
        // read and clear in the same pass
        we         = 1'b1;
        scan_vld_d = 1'b1;
        scan_idx_d = addr_q;
        addr_d     = addr_q + 1'b1;
        if (last_addr) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        step_d  = '0;
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (first_q) begin
          slow_d      = RW'({lo_q, 16'b0});
          shigh_d     = RW'({hi_q, 16'b0});
          first_d     = 1'b0;
          out_d       = '{pixel_out: 8'd0, range_low: RW'({lo_q, 16'b0}),
                          range_high: RW'({hi_q, 16'b0})};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          step_d = step_q + 1'b1;
          if (step_q != 3'd6) prod_d = PW'(mul_a * mul_b);
          case (step_q)
            3'd1, 3'd4: acc_d = ACW'(prod_q >> 16);
            3'd2, 3'd5: acc_d = acc_q + ACW'(prod_q);
            3'd3:       new_low_d = RW'(acc_q + ACW'(prod_q));
            3'd6: begin
              slow_d      = new_low_q;
              shigh_d     = RW'(acc_q + ACW'(prod_q));
              first_d     = 1'b0;
              out_d       = '{pixel_out: 8'd0, range_low: new_low_q,
                              range_high: RW'(acc_q + ACW'(prod_q))};
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
            default: acc_d = acc_q;
          endcase
        end
      end
      ST_MPREP: begin
        if (shigh_q <= slow_q || pq <= slow_q) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          diff_d  = pq - slow_q;
          den_d   = shigh_q - slow_q;
          state_d = ST_MNUM;
        end
      end
      ST_MNUM: begin
        // times 255 as shift and subtract
        rem_d   = {diff_q, 8'b0} - 41'(diff_q);
        dsh_d   = {den_q, 8'b0};
        k_d     = 4'd8;
        qt_d    = '0;
        state_d = ST_MDIV;
      end
      ST_MDIV: begin
        dsh_d = dsh_q >> 1;
        k_d   = k_q - 1'b1;
        if (k_q == 4'd8) begin
          if (ge) begin
            out_d.pixel_out = 8'hFF;
            out_valid_d     = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          if (ge) rem_d = rem_q - dsh_q;
          qt_d = {qt_q[6:0], ge};
          if (k_q == 4'd0) begin
            out_d.pixel_out = {qt_q[6:0], ge};
            out_valid_d     = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      minc_q      <= harng_pkg::MINC_RESET;
      keep_q      <= harng_pkg::KEEP_RESET;
      addr_q      <= '0;
      scan_vld_q  <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
      slow_q      <= harng_pkg::LOW_RESET;
      shigh_q     <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      minc_q      <= minc_d;
      keep_q      <= keep_d;
      addr_q      <= addr_d;
      scan_vld_q  <= scan_vld_d;
      step_q      <= step_d;
      k_q         <= k_d;
      slow_q      <= slow_d;
      shigh_q     <= shigh_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_addr_q <= cnt_addr_d;
    scan_idx_q <= scan_idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pix_q      <= pix_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    new_low_q  <= new_low_d;
    diff_q     <= diff_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    qt_q       <= qt_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/histogram_auto_range_16_to_8_unit.sv */
// a count item reads and increments its bucket; a map item may run a 9-step divider
// a close item does a read-and-clear sweep, then loads (first frame) or blends the range
// a 4-entry command queue takes requests while the back end works or the output waits
// reset: range returns to 65535.0 and 0, then a clearing pass over all BUCKETS entries
// zeroes the histogram ram, with the input stalled; config writes are taken throughout
// ----------------------------------------------------------------------------
// histogram_auto_range_16_to_8_unit
// 16 to 8 bit pixel mapping with a histogram driven, smoothed range
// ----------------------------------------------------------------------------
module histogram_auto_range_16_to_8_unit #(
  parameter int unsigned BUCKETS = 32769
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  harng_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output harng_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [20:0]     cfg_data_i
);

  logic            cmd_valid;
  harng_pkg::cmd_t cmd;
  harng_pkg::ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  harng_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .ctl_i       (ctl)
  );

  harng_back #(.BUCKETS(BUCKETS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .ctl_o       (ctl),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/harng_checker.sv */
// ----------------------------------------------------------------------------
// harng_assert
// port level checks of the histogram auto range unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module harng_assert (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input harng_pkg::out_t out_data_o
);

  logic out_wait, low_ok, high_ok, quiet;

  assign out_wait = out_valid_o && out_stall_i;
  assign low_ok   = !out_data_o.range_low[32] || (out_data_o.range_low[31:0] == 32'd0);
  assign high_ok  = !out_data_o.range_high[32] || (out_data_o.range_high[31:0] == 32'd0);
  assign quiet    = !out_valid_o && in_stall_o;

  `HARNG_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data_o), "result moved")
  `HARNG_ASSERT(a_low_bound, !out_valid_o || low_ok, "range_low above 65536.0")
  `HARNG_ASSERT(a_high_bound, !out_valid_o || high_ok, "range_high above 65536.0")
  `HARNG_ASSERT(a_reset_quiet, !$rose(rst_ni) || quiet, "result or no stall after reset")
  `HARNG_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i, "stalled request dropped")

endmodule

bind histogram_auto_range_16_to_8_unit harng_assert u_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* sim/harng_checker.sv */
// ----------------------------------------------------------------------------
// harng_checker
// watches the request, result and register channels of the histogram range
// unit, predicts each result from its own copy of the state and compares
// ----------------------------------------------------------------------------
module harng_checker #(
  parameter int unsigned BUCKETS = 32769
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  harng_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  harng_pkg::out_t out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [20:0]     cfg_data_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  int unsigned       hist_count [int unsigned];
  longint unsigned   smooth_lo;
  longint unsigned   smooth_hi;
  bit                fresh_frame;
  int unsigned       min_count;
  longint unsigned   keep_w;
  harng_pkg::out_t   expected_q [$];

  function automatic longint unsigned blend_range(longint unsigned old_q, longint unsigned val,
                                                  longint unsigned w);
    return (w * old_q + (64'd65536 - w) * (val << 16)) >> 16;
  endfunction

  function automatic harng_pkg::out_t predict_pixel(harng_pkg::in_t req);
    harng_pkg::out_t res;
    int unsigned     idx;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned w;
    longint unsigned pq;
    longint unsigned q;
    res = '0;
    case (req.action)
      harng_pkg::ACT_COUNT: begin
        idx = (int'(req.pixel_in) + 1) >> 1;
        if (idx >= BUCKETS) idx = BUCKETS - 1;
        if (!hist_count.exists(idx)) hist_count[idx] = 0;
        if (hist_count[idx] < 32'(harng_pkg::COUNT_MAX)) hist_count[idx]++;
      end
      harng_pkg::ACT_CLOSE: begin
        lo = 65535;
        hi = 0;
        w = (keep_w > 65536) ? 65536 : keep_w;
        foreach (hist_count[i]) begin
          if (hist_count[i] > min_count) begin
            if (64'(2 * i) < lo) lo = 64'(2 * i);
            if (64'(2 * i) > hi) hi = 64'(2 * i);
          end
        end
        if (fresh_frame) begin
          smooth_lo = lo << 16;
          smooth_hi = hi << 16;
        end else begin
          smooth_lo = blend_range(smooth_lo, lo, w);
          smooth_hi = blend_range(smooth_hi, hi, w);
        end
        fresh_frame = 1'b0;
        hist_count.delete();
      end
      harng_pkg::ACT_MAP: begin
        pq = 64'(req.pixel_in) << 16;
        if (smooth_hi > smooth_lo && pq > smooth_lo) begin
          q = ((pq - smooth_lo) * 255) / (smooth_hi - smooth_lo);
          res.pixel_out = (q > 255) ? 8'd255 : q[7:0];
        end
      end
      default: ;
    endcase
    res.range_low = smooth_lo[harng_pkg::RANGE_W-1:0];
    res.range_high = smooth_hi[harng_pkg::RANGE_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    harng_pkg::out_t want;
    if (!rst_ni) begin
      hist_count.delete();
      expected_q.delete();
      smooth_lo = 64'h0000_0000_FFFF_0000;
      smooth_hi = 0;
      fresh_frame = 1'b1;
      min_count = 32'(harng_pkg::MINC_RESET);
      keep_w = 64'(harng_pkg::KEEP_RESET);
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == harng_pkg::REG_MIN_COUNT) min_count = 32'(cfg_data_i);
        else if (cfg_index_i == harng_pkg::REG_KEEP)
          keep_w = 64'(cfg_data_i[harng_pkg::KEEP_W-1:0]);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("%0t: result with no request pending: %p",
                                          $realtime, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_data_i) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch pix exp %0d got %0d, low exp %h got %h, high exp %h got %h",
                       $realtime, want.pixel_out, out_data_i.pixel_out, want.range_low,
                       out_data_i.range_low, want.range_high, out_data_i.range_high);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_pixel(in_data_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

/* sim/tb_histogram_auto_range_16_to_8_unit.sv */
// ----------------------------------------------------------------------------
// tb_histogram_auto_range_16_to_8_unit
// drives frames of count, close and map requests with bursty input and a
// stalling receiver, changes thresholds and smoothing between frames, and
// leaves all result checking to the checker
// ----------------------------------------------------------------------------
module tb_histogram_auto_range_16_to_8_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_IDLE = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  harng_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  harng_pkg::out_t out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [20:0]     cfg_data = '0;
  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     burst_left = 0;
  int unsigned     cycles = 0;

  always #5 clk_i = ~clk_i;

  histogram_auto_range_16_to_8_unit u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  harng_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern: quiet, random or alternating, chosen by bits 7:6 of the cycle counter
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    case (cycles[7:6])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= cycles[0];
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL histogram_auto_range_16_to_8_unit");
      $finish;
    end
  end

  task automatic send_pixel(input logic [1:0] act, input logic [15:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_data <= '{action: act, pixel_in: pix};
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_frame(input int unsigned n);
    int unsigned base;
    int unsigned span;
    int unsigned pick;
    span = $urandom_range(8, 3000);
    base = $urandom_range(0, 65535 - span);
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) send_pixel(harng_pkg::ACT_COUNT, 16'(base + $urandom_range(0, span)));
      else if (pick < 85) send_pixel(harng_pkg::ACT_COUNT, 16'($urandom_range(0, 65535)));
      else if (pick < 97) send_pixel(harng_pkg::ACT_MAP, 16'($urandom_range(0, 65535)));
      else send_pixel(ACT_IDLE, 16'($urandom_range(0, 65535)));
    end
    send_pixel(harng_pkg::ACT_CLOSE, 16'($urandom_range(0, 65535)));
    for (int unsigned k = 0; k < 15; k++)
      send_pixel(harng_pkg::ACT_MAP,
                 16'((k < 10) ? base + $urandom_range(0, span) : $urandom_range(0, 65535)));
  endtask

  initial begin
    logic [20:0] min_set [7];
    logic [20:0] keep_set [6];
    min_set = '{21'd0, 21'd1, 21'd2, 21'd16, 21'd1048576, 21'h1FFFFF, 21'd3};
    keep_set = '{21'd0, 21'd65536, 21'd131071, 21'd62259, 21'd32768, 21'd1};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // map before any close, unused action, extreme pixels, empty first frame
    send_pixel(harng_pkg::ACT_MAP, 16'd0);
    send_pixel(harng_pkg::ACT_MAP, 16'hFFFF);
    send_pixel(ACT_IDLE, 16'hFFFF);
    send_pixel(harng_pkg::ACT_COUNT, 16'd0);
    send_pixel(harng_pkg::ACT_COUNT, 16'hFFFF);
    send_pixel(harng_pkg::ACT_CLOSE, 16'd0);
    drain();
    write_reg(harng_pkg::REG_MIN_COUNT, 21'd0);
    write_reg(harng_pkg::REG_KEEP, 21'd65536);
    send_pixel(harng_pkg::ACT_COUNT, 16'd1);
    send_pixel(harng_pkg::ACT_COUNT, 16'd2);
    send_pixel(harng_pkg::ACT_COUNT, 16'hFFFE);
    send_pixel(harng_pkg::ACT_COUNT, 16'hFFFF);
    send_pixel(harng_pkg::ACT_CLOSE, 16'hFFFF);
    send_pixel(harng_pkg::ACT_MAP, 16'd0);
    send_pixel(harng_pkg::ACT_MAP, 16'd1);
    send_pixel(harng_pkg::ACT_MAP, 16'h8000);
    send_pixel(harng_pkg::ACT_MAP, 16'hFFFE);
    send_pixel(harng_pkg::ACT_MAP, 16'hFFFF);
    send_pixel(harng_pkg::ACT_COUNT, 16'h5555);
    send_pixel(harng_pkg::ACT_CLOSE, 16'h0);
    send_pixel(harng_pkg::ACT_MAP, 16'h5555);
    drain();
    write_reg(REG_SPARE_A, 21'h1FFFFF);
    write_reg(REG_SPARE_B, 21'h0);

    // random frames under changing threshold and smoothing
    for (int unsigned ph = 0; ph < 9; ph++) begin
      write_reg(harng_pkg::REG_MIN_COUNT,
                21'((ph % 3 == 2) ? min_set[ph % 7] : $urandom_range(0, 3)));
      write_reg(harng_pkg::REG_KEEP,
                21'((ph < 6) ? keep_set[ph] : $urandom_range(0, 131071)));
      run_frame($urandom_range(70, 110));
      run_frame($urandom_range(70, 110));
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS histogram_auto_range_16_to_8_unit");
    end else begin
      $display("FAIL histogram_auto_range_16_to_8_unit");
    end
    $finish;
  end

endmodule

/* histogram_auto_range_16_to_8_unit.f */
+incdir+design
design/harng_pkg.sv
design/harng_ram.sv
design/harng_front.sv
design/harng_back.sv
design/histogram_auto_range_16_to_8_unit.sv
design/harng_checker.sv
sim/harng_checker.sv
sim/tb_histogram_auto_range_16_to_8_unit.sv
